FILE: hw/rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/s512_pkg.sv
// Package: transaction types, control structs and SHA-512 constants.
`default_nettype none
package s512_pkg;

  typedef struct packed {
    logic [63:0] data_word;
    logic [3:0]  valid_bytes;
    logic        end_of_message;
  } s512_in_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } s512_out_t;

  // Commands from the stream front end to the compression core
  typedef struct packed {
    logic start;
    logic reinit;
  } s512_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } s512_sts_t;

  localparam int unsigned NumRounds = 80;

  localparam logic [63:0] RoundK [NumRounds] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam logic [63:0] InitH [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

endpackage
`default_nettype wire

FILE: hw/rtl/s512_round.sv
// One SHA-512 round and one message schedule step, purely combinational.
`default_nettype none
module s512_round (
  input  wire logic [63:0] v_i [8],
  input  wire logic [63:0] k_i,
  input  wire logic [63:0] w0_i,
  input  wire logic [63:0] w1_i,
  input  wire logic [63:0] w9_i,
  input  wire logic [63:0] w14_i,
  output logic      [63:0] v_o [8],
  output logic      [63:0] w_new_o
);

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  logic [63:0] t1, t2, ch, maj, sum_e, sum_a, s0, s1;

  // Compression round
  always_comb begin
    sum_e = rotr(v_i[4], 14) ^ rotr(v_i[4], 18) ^ rotr(v_i[4], 41);
    sum_a = rotr(v_i[0], 28) ^ rotr(v_i[0], 34) ^ rotr(v_i[0], 39);
    ch    = (v_i[4] & v_i[5]) ^ (~v_i[4] & v_i[6]);
    maj   = (v_i[0] & v_i[1]) ^ (v_i[0] & v_i[2]) ^ (v_i[1] & v_i[2]);
    t1    = v_i[7] + sum_e + ch + k_i + w0_i;
    t2    = sum_a + maj;
    v_o[7] = v_i[6];
    v_o[6] = v_i[5];
    v_o[5] = v_i[4];
    v_o[4] = v_i[3] + t1;
    v_o[3] = v_i[2];
    v_o[2] = v_i[1];
    v_o[1] = v_i[0];
    v_o[0] = t1 + t2;
  end

  // Schedule word sixteen ahead of the current one
  always_comb begin
    s0 = rotr(w1_i, 1) ^ rotr(w1_i, 8) ^ (w1_i >> 7);
    s1 = rotr(w14_i, 19) ^ rotr(w14_i, 61) ^ (w14_i >> 6);
    w_new_o = s1 + w9_i + s0 + w0_i;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/s512_core.sv
// Compression core: 80 rounds through one shared round unit, then chain update.
`default_nettype none
module s512_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire s512_pkg::s512_cmd_t   cmd_i,
  input  wire logic [63:0]           blk_i [16],
  output s512_pkg::s512_sts_t        sts_o,
  output logic [63:0]                h_o [8]
);
  import s512_pkg::*;

  typedef enum logic [2:0] {
    CS_IDLE   = 3'b001,
    CS_ROUND  = 3'b010,
    CS_FINISH = 3'b100
  } core_state_e;

  core_state_e state_q, state_d;
  logic [6:0]  t_q, t_d;
  logic [63:0] h_q [8];
  logic [63:0] v_q [8];
  logic [63:0] w_q [16];
  logic [63:0] v_nxt [8];
  logic [63:0] w_new;
  logic        done_q;

  s512_round u_round (
    .v_i     (v_q),
    .k_i     (RoundK[t_q]),
    .w0_i    (w_q[0]),
    .w1_i    (w_q[1]),
    .w9_i    (w_q[9]),
    .w14_i   (w_q[14]),
    .v_o     (v_nxt),
    .w_new_o (w_new)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    t_d     = t_q;
    unique case (state_q)
      CS_IDLE: begin
        if (cmd_i.start) begin
          state_d = CS_ROUND;
          t_d     = '0;
        end
      end
      CS_ROUND: begin
        t_d = t_q + 7'd1;
        if (t_q == 7'(NumRounds - 1)) state_d = CS_FINISH;
      end
      CS_FINISH: state_d = CS_IDLE;
      default:   state_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      t_q     <= '0;
      done_q  <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
    end else begin
      state_q <= state_d;
      t_q     <= t_d;
      done_q  <= (state_q == CS_FINISH);
      if (cmd_i.reinit) begin
        for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
      end else if (state_q == CS_FINISH) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
    end
  end

  // Working variables and schedule window
  always_ff @(posedge clk_i) begin
    if (state_q == CS_IDLE && cmd_i.start) begin
      for (int i = 0; i < 8; i++)  v_q[i] <= h_q[i];
      for (int i = 0; i < 16; i++) w_q[i] <= blk_i[i];
    end else if (state_q == CS_ROUND) begin
      for (int i = 0; i < 8; i++)  v_q[i] <= v_nxt[i];
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
    end
  end

  assign sts_o.busy = (state_q != CS_IDLE);
  assign sts_o.done = done_q;
  assign h_o        = h_q;

endmodule
`default_nettype wire

FILE: hw/rtl/sha512_stream_hash.sv
// Top level: streaming SHA-512 with byte packing, padding and digest output.
//
//  channel | direction | payload     | handshake
//  in      | input     | s512_in_t   | in_valid_i / in_ready_o
//  out     | output    | s512_out_t  | out_valid_o / out_ready_i
//
// A word is accepted, packed (in two parts when it spans two block words, not at
// all when it carries no bytes) and checked for leftover bytes. Filling a block adds
// compression on the single round unit (80 rounds, chain update, handoff).
// The end of a message adds padding, one or two compressions and eight
// digest transactions. in_ready_o is high only while the block is idle.
// The digest holds while out_ready_i is low. Reset loads the initial hash.
`default_nettype none
module sha512_stream_hash (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire s512_pkg::s512_in_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output s512_pkg::s512_out_t       out_data_o
);
  import s512_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_ABSORB = 7'b0000010,
    ST_PAD    = 7'b0000100,
    ST_LEN    = 7'b0001000,
    ST_LAUNCH = 7'b0010000,
    ST_WAIT   = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_e;

  state_e       state_q, state_d, ret_q, ret_d;
  logic [63:0]  data_q, data_d;
  logic [3:0]   n_q, n_d;
  logic         eom_q, eom_d;
  logic [6:0]   fill_q, fill_d;
  logic [127:0] count_q, count_d;
  logic         ovf_q, ovf_d;
  logic [2:0]   idx_q, idx_d;
  logic         oval_q, oval_d;
  logic [63:0]  blk_q [16];
  logic [63:0]  blk_d [16];

  s512_cmd_t    cmd;
  s512_sts_t    sts;
  logic [63:0]  h [8];

  logic [2:0]   off;
  logic [3:0]   room, take, n_sat;
  logic [7:0]   fill_sum;
  logic [3:0]   end_byte;
  logic [63:0]  hi_mask, lo_mask, wr_mask;
  logic [127:0] bit_len;
  logic         in_acc, out_acc;

  s512_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .blk_i  (blk_q),
    .sts_o  (sts),
    .h_o    (h)
  );

  assign in_acc  = in_valid_i & in_ready_o;
  assign out_acc = oval_q & out_ready_i;

  // Byte placement within the current block word
  always_comb begin
    off      = fill_q[2:0];
    room     = 4'd8 - {1'b0, off};
    take     = (n_q < room) ? n_q : room;
    fill_sum = {1'b0, fill_q} + {4'b0, take};
    end_byte = {1'b0, off} + take;
    hi_mask  = {64{1'b1}} >> {off, 3'b000};
    lo_mask  = {64{1'b1}} >> {end_byte, 3'b000};
    wr_mask  = hi_mask & ~lo_mask;
    n_sat    = (in_data_i.valid_bytes > 4'd8) ? 4'd8 : in_data_i.valid_bytes;
    bit_len  = {count_q[124:0], 3'b000};
  end

  // Front-end sequencer
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    data_d  = data_q;
    n_d     = n_q;
    eom_d   = eom_q;
    fill_d  = fill_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    idx_d   = idx_q;
    oval_d  = oval_q;
    blk_d   = blk_q;
    cmd     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          data_d  = in_data_i.data_word;
          n_d     = n_sat;
          eom_d   = in_data_i.end_of_message;
          state_d = ST_ABSORB;
        end
      end
      ST_ABSORB: begin
        if (n_q == 4'd0) begin
          state_d = eom_q ? ST_PAD : ST_IDLE;
        end else begin
          blk_d[fill_q[6:3]] = (blk_q[fill_q[6:3]] & ~wr_mask)
                             | ((data_q >> {off, 3'b000}) & wr_mask);
          data_d = data_q << {take, 3'b000};
          n_d    = n_q - take;
          fill_d = fill_sum[6:0];
          if (fill_sum[7]) begin
            count_d = count_q + 128'd128;
            ret_d   = ST_ABSORB;
            state_d = ST_LAUNCH;
          end
        end
      end
      ST_PAD: begin
        // 0x80 after the last byte, zeros to the end of the block
        count_d = count_q + {121'b0, fill_q};
        blk_d[fill_q[6:3]] = (blk_q[fill_q[6:3]] & ~hi_mask)
                           | ({8'h80, 56'b0} >> {off, 3'b000});
        for (int i = 0; i < 16; i++) begin
          if (4'(i) > fill_q[6:3]) blk_d[i] = '0;
        end
        ovf_d = (fill_q >= 7'd112);
        if (fill_q >= 7'd112) begin
          ret_d   = ST_LEN;
          state_d = ST_LAUNCH;
        end else begin
          state_d = ST_LEN;
        end
      end
      ST_LEN: begin
        if (ovf_q) begin
          for (int i = 0; i < 14; i++) blk_d[i] = '0;
        end
        blk_d[14] = bit_len[127:64];
        blk_d[15] = bit_len[63:0];
        ret_d     = ST_EMIT;
        state_d   = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        cmd.start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts.done) begin
          state_d = ret_q;
          if (ret_q == ST_EMIT) begin
            oval_d = 1'b1;
            idx_d  = '0;
          end
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (idx_q == 3'd7) begin
            oval_d     = 1'b0;
            cmd.reinit = 1'b1;
            count_d    = '0;
            fill_d     = '0;
            state_d    = ST_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      fill_q  <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
      idx_q   <= '0;
      oval_q  <= 1'b0;
      n_q     <= '0;
      eom_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      fill_q  <= fill_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      idx_q   <= idx_d;
      oval_q  <= oval_d;
      n_q     <= n_d;
      eom_q   <= eom_d;
    end
  end

  // Block buffer and word holding register
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    blk_q  <= blk_d;
  end

  assign in_ready_o             = (state_q == ST_IDLE);
  assign out_valid_o            = oval_q;
  assign out_data_o.digest_word = h[idx_q];
  assign out_data_o.word_index  = idx_q;
  assign out_data_o.last_word   = (idx_q == 3'd7);

endmodule
`default_nettype wire

FILE: hw/rtl/s512_checker.sv
// Port-level checker for the streaming SHA-512 block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module s512_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire s512_pkg::s512_in_t  in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire s512_pkg::s512_out_t out_data_o
);

  // A stalled digest word holds
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_data_o))
  // The last flag marks only the eighth word
  `ASSERT_NOW(a_last_idx, clk_i, rst_ni, out_valid_o, out_data_o.last_word == (out_data_o.word_index == 3'd7))
  // Digest words follow back to back until the eighth
  `ASSERT_NEXT(a_burst, clk_i, rst_ni, out_valid_o && out_ready_i && !out_data_o.last_word, out_valid_o && (out_data_o.word_index == $past(out_data_o.word_index) + 3'd1))
  // An accepted transaction makes the block busy
  `ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // No new input while a digest is out
  `ASSERT_NOW(a_excl, clk_i, rst_ni, out_valid_o, !in_ready_o)

endmodule

bind sha512_stream_hash s512_checker u_s512_checker (.*);
`default_nettype wire
